@@ sv/ilist_pkg.sv @@
package ilist_pkg;

  // List geometry
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // Port field widths
  localparam int OP_W     = 3;
  localparam int POS_W    = 5;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 5;

  localparam int IN_W   = OP_W + POS_W + VAL_W;
  localparam int OUT_W  = STATUS_W + VAL_W + LEN_W;
  localparam int IN_TW  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

  // Request operations
  typedef enum logic [OP_W-1:0] {
    OP_APPEND      = 3'd0,
    OP_INSERT      = 3'd1,
    OP_REMOVE      = 3'd2,
    OP_READ        = 3'd3,
    OP_REMOVE_LAST = 3'd4
  } op_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Per-cell update command
  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_LOAD       = 2'd1,
    CELL_FROM_LOWER = 2'd2,
    CELL_FROM_UPPER = 2'd3
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t              cmd;
    logic [DATA_WIDTH-1:0]  new_val;
  } cell_ctl_t;

endpackage

@@ sv/ilist_cell.sv @@
module ilist_cell (
  input  logic                              clk,
  input  ilist_pkg::cell_ctl_t              ctl,
  input  logic [ilist_pkg::DATA_WIDTH-1:0]  lower_val,  // entry one place down
  input  logic [ilist_pkg::DATA_WIDTH-1:0]  upper_val,  // entry one place up
  output logic [ilist_pkg::DATA_WIDTH-1:0]  data
);

  logic [ilist_pkg::DATA_WIDTH-1:0] data_next;

  // Pick the source for this slot
  always_comb begin
    case (ctl.cmd)
      ilist_pkg::CELL_LOAD:       data_next = ctl.new_val;
      ilist_pkg::CELL_FROM_LOWER: data_next = lower_val;
      ilist_pkg::CELL_FROM_UPPER: data_next = upper_val;
      default:                    data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

@@ sv/indexed_list_insert_remove.sv @@
// Indexed list built as a row of cells, one list entry per cell.
// The result of an item is registered and appears on m_tvalid the cycle after acceptance.
// Throughput: one item per cycle while m_tready is high; every cell shifts, loads or holds.
// Reset (rst, synchronous): length goes to zero and the result register empties;
// cell contents are not cleared and only entries below the length are ever read.
module indexed_list_insert_remove (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [ilist_pkg::IN_TW-1:0]     s_tdata,   // op[2:0], position[7:3], item_value[39:8]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [ilist_pkg::OUT_TW-1:0]    m_tdata    // status[1:0], read_value[33:2],
                                                     // list_length[38:34], zero[39]
);

  localparam int DW = ilist_pkg::DATA_WIDTH;
  localparam int CW = ilist_pkg::CNT_W;

  // Request fields
  ilist_pkg::op_t              op;
  logic [ilist_pkg::POS_W-1:0] position;
  logic [ilist_pkg::VAL_W-1:0] item_value;

  assign op         = ilist_pkg::op_t'(s_tdata[ilist_pkg::OP_W-1:0]);
  assign position   = s_tdata[ilist_pkg::OP_W +: ilist_pkg::POS_W];
  assign item_value = s_tdata[ilist_pkg::OP_W + ilist_pkg::POS_W +: ilist_pkg::VAL_W];

  // State
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          out_valid;
  logic [ilist_pkg::OUT_W-1:0] out_data;

  logic [DW-1:0] cell_data [ilist_pkg::DEPTH];

  logic accept;
  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // Decode the request
  logic [CW:0]     pos_ext;      // one bit wider so position 16+ compares correctly
  logic            is_rem;
  logic            do_ins;
  logic            do_rem;
  ilist_pkg::status_t status;
  logic [DW-1:0]   got;
  logic [ilist_pkg::IDX_W-1:0] pos_idx;

  always_comb begin
    is_rem = (op == ilist_pkg::OP_REMOVE) || (op == ilist_pkg::OP_REMOVE_LAST);
    case (op)
      ilist_pkg::OP_APPEND:      pos_ext = {1'b0, count};
      ilist_pkg::OP_REMOVE_LAST: pos_ext = {1'b0, count} - (CW+1)'(1);
      default:                   pos_ext = (CW+1)'(position);
    endcase
    pos_idx = pos_ext[ilist_pkg::IDX_W-1:0];

    do_ins = 1'b0;
    do_rem = 1'b0;
    got    = '0;
    case (op)
      ilist_pkg::OP_APPEND, ilist_pkg::OP_INSERT: begin
        if (pos_ext > {1'b0, count}) begin
          status = ilist_pkg::ST_RANGE;
        end else if (count == CW'(ilist_pkg::DEPTH)) begin
          status = ilist_pkg::ST_FULL;
        end else begin
          status = ilist_pkg::ST_DONE;
          do_ins = 1'b1;
        end
      end
      ilist_pkg::OP_REMOVE, ilist_pkg::OP_REMOVE_LAST, ilist_pkg::OP_READ: begin
        if (count == '0 || pos_ext >= {1'b0, count}) begin
          status = ilist_pkg::ST_RANGE;
        end else begin
          status = ilist_pkg::ST_DONE;
          do_rem = is_rem;
          got    = cell_data[pos_idx];
        end
      end
      default: status = ilist_pkg::ST_RANGE;
    endcase

    count_next = count;
    if (do_ins) count_next = count + CW'(1);
    else if (do_rem) count_next = count - CW'(1);
  end

  // Per-cell commands: insert shifts up above the position, remove shifts down from it
  for (genvar k = 0; k < ilist_pkg::DEPTH; k++) begin : g_cell
    ilist_pkg::cell_ctl_t ctl;
    logic [DW-1:0] lower_v;
    logic [DW-1:0] upper_v;

    always_comb begin
      ctl.new_val = DW'(item_value);
      ctl.cmd     = ilist_pkg::CELL_HOLD;
      if (accept && do_ins) begin
        if ((CW+1)'(k) == pos_ext) ctl.cmd = ilist_pkg::CELL_LOAD;
        else if ((CW+1)'(k) > pos_ext) ctl.cmd = ilist_pkg::CELL_FROM_LOWER;
      end else if (accept && do_rem) begin
        if ((CW+1)'(k) >= pos_ext && k < ilist_pkg::DEPTH - 1)
          ctl.cmd = ilist_pkg::CELL_FROM_UPPER;
      end
    end

    if (k == 0) begin : g_first
      assign lower_v = cell_data[k];
    end else begin : g_mid_lo
      assign lower_v = cell_data[k-1];
    end
    if (k == ilist_pkg::DEPTH - 1) begin : g_last
      assign upper_v = cell_data[k];
    end else begin : g_mid_hi
      assign upper_v = cell_data[k+1];
    end

    ilist_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .lower_val (lower_v),
      .upper_val (upper_v),
      .data      (cell_data[k])
    );
  end

  // Length and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) count <= count_next;
      if (accept) out_valid <= 1'b1;
      else if (m_tready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= {ilist_pkg::LEN_W'(count_next), ilist_pkg::VAL_W'(got), status};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = ilist_pkg::OUT_TW'(out_data);

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(ilist_pkg::DEPTH))
    else $error("list length beyond depth");

  a_accept_shows: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("accepted item produced no result");

  a_full_len: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1:0] == ilist_pkg::ST_FULL)
      |-> m_tdata[38:34] == ilist_pkg::LEN_W'(ilist_pkg::DEPTH))
    else $error("full status with list not full");

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1:0] != ilist_pkg::ST_DONE) |-> m_tdata[33:2] == '0)
    else $error("refused request returned data");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    accept |=> (count == $past(count) || count == $past(count) + CW'(1)
                || count == $past(count) - CW'(1)))
    else $error("length changed by more than one");

endmodule
